/* design/mbsp_pkg.sv */
// ----------------------------------------------------------------------------
// MIDI byte stream parser package
// Shared types, event codes and the channel message decode function.
// ----------------------------------------------------------------------------
`default_nettype none

package mbsp_pkg;

	// Parse phase, one-hot.
	typedef enum logic [4:0] {
		PH_IDLE  = 5'b00001,
		PH_DATA1 = 5'b00010,
		PH_DATA2 = 5'b00100,
		PH_SYSEX = 5'b01000,
		PH_SKIP  = 5'b10000
	} phase_t;

	// Event kind codes.
	localparam logic [2:0] KIND_NOTE_OFF   = 3'd0;
	localparam logic [2:0] KIND_NOTE_ON    = 3'd1;
	localparam logic [2:0] KIND_POLY_PRESS = 3'd2;
	localparam logic [2:0] KIND_CONTROLLER = 3'd3;
	localparam logic [2:0] KIND_PROGRAM    = 3'd4;
	localparam logic [2:0] KIND_CHAN_PRESS = 3'd5;
	localparam logic [2:0] KIND_BEND       = 3'd6;
	localparam logic [2:0] KIND_SYSEX      = 3'd7;

	// Status byte values and status type nibbles.
	localparam logic [7:0] SYSEX_START = 8'hF0;
	localparam logic [7:0] SYSEX_END   = 8'hF7;
	localparam logic [3:0] TYPE_NOTE_OFF   = 4'h8;
	localparam logic [3:0] TYPE_NOTE_ON    = 4'h9;
	localparam logic [3:0] TYPE_POLY_PRESS = 4'hA;
	localparam logic [3:0] TYPE_CONTROLLER = 4'hB;
	localparam logic [3:0] TYPE_PROGRAM    = 4'hC;
	localparam logic [3:0] TYPE_CHAN_PRESS = 4'hD;
	localparam logic [3:0] TYPE_BEND       = 4'hE;
	localparam logic [3:0] TYPE_SYSTEM     = 4'hF;

	// Parser state carried from one byte to the next.
	typedef struct packed {
		logic [7:0] last_status;
		phase_t     phase;
		logic [7:0] held;
	} state_t;

	// One result item.
	typedef struct packed {
		logic [2:0]  event_kind;
		logic [3:0]  channel;
		logic [14:0] first_value;
		logic [7:0]  second_value;
		logic        sysex_last;
	} result_t;

	// True for status types that carry two data bytes.
	function automatic logic needs_two(input logic [7:0] status);
		return status[7:4] inside {TYPE_NOTE_OFF, TYPE_NOTE_ON, TYPE_POLY_PRESS,
			TYPE_CONTROLLER, TYPE_BEND};
	endfunction

	// Build the event for a completed channel message.
	function automatic result_t channel_event(input logic [7:0] status,
		input logic [7:0] d1, input logic [7:0] d2);
		result_t r;
		r.channel      = status[3:0];
		r.first_value  = {7'd0, d1};
		r.second_value = d2;
		r.sysex_last   = 1'b0;
		case (status[7:4])
			TYPE_NOTE_OFF:   r.event_kind = KIND_NOTE_OFF;
			TYPE_NOTE_ON: begin
				// A note on with zero velocity is reported as a note off.
				r.event_kind = (d2 == 8'd0) ? KIND_NOTE_OFF : KIND_NOTE_ON;
			end
			TYPE_POLY_PRESS: r.event_kind = KIND_POLY_PRESS;
			TYPE_CONTROLLER: r.event_kind = KIND_CONTROLLER;
			TYPE_PROGRAM: begin
				r.event_kind   = KIND_PROGRAM;
				r.second_value = 8'd0;
			end
			TYPE_CHAN_PRESS: begin
				r.event_kind   = KIND_CHAN_PRESS;
				r.second_value = 8'd0;
			end
			default: begin
				r.event_kind   = KIND_BEND;
				r.first_value  = {7'd0, d1} | {d2, 7'd0};
				r.second_value = 8'd0;
			end
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

/* design/mbsp_if.sv */
// ----------------------------------------------------------------------------
// MIDI byte stream parser channel interfaces
// Valid/ready channels for input bytes and output events.
// ----------------------------------------------------------------------------
`default_nettype none

interface mbsp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       packet_end;

	modport source (output valid, output in_byte, output packet_end, input ready);
	modport sink   (input valid, input in_byte, input packet_end, output ready);
endinterface

interface mbsp_event_if;
	logic        valid;
	logic        ready;
	logic [2:0]  event_kind;
	logic [3:0]  channel;
	logic [14:0] first_value;
	logic [7:0]  second_value;
	logic        sysex_last;

	modport source (output valid, output event_kind, output channel, output first_value,
		output second_value, output sysex_last, input ready);
	modport sink   (input valid, input event_kind, input channel, input first_value,
		input second_value, input sysex_last, output ready);
endinterface

`default_nettype wire

/* design/mbsp_decode.sv */
// ----------------------------------------------------------------------------
// MIDI byte stream parser decode step
// Combinational step: next parser state and the optional result for one byte.
// ----------------------------------------------------------------------------
`default_nettype none

module mbsp_decode (
	input  mbsp_pkg::state_t  cur,
	input  logic [7:0]        in_byte,
	input  logic              packet_end,
	output mbsp_pkg::state_t  nxt,
	output logic              emit,
	output mbsp_pkg::result_t res
);

	mbsp_pkg::phase_t np;
	logic             sysex_stop;

	assign sysex_stop = (in_byte == mbsp_pkg::SYSEX_END) || packet_end;

	// Phase dispatch; unknown phase codes behave like idle.
	always_comb begin
		nxt  = cur;
		np   = mbsp_pkg::PH_IDLE;
		emit = 1'b0;
		res  = '0;
		case (cur.phase)
			mbsp_pkg::PH_DATA1: begin
				if (mbsp_pkg::needs_two(cur.last_status)) begin
					nxt.held = in_byte;
					np       = mbsp_pkg::PH_DATA2;
				end else begin
					emit = 1'b1;
					res  = mbsp_pkg::channel_event(cur.last_status, in_byte, 8'd0);
				end
			end
			mbsp_pkg::PH_DATA2: begin
				emit = 1'b1;
				res  = mbsp_pkg::channel_event(cur.last_status, cur.held, in_byte);
			end
			mbsp_pkg::PH_SYSEX: begin
				emit            = 1'b1;
				res.event_kind  = mbsp_pkg::KIND_SYSEX;
				res.first_value = {7'd0, in_byte};
				res.sysex_last  = sysex_stop;
				np = sysex_stop ? mbsp_pkg::PH_IDLE : mbsp_pkg::PH_SYSEX;
			end
			mbsp_pkg::PH_SKIP: begin
				np = mbsp_pkg::PH_SKIP;
			end
			default: begin
				if (in_byte == mbsp_pkg::SYSEX_START) begin
					// Sysex opens; running status is left alone.
					emit            = 1'b1;
					res.event_kind  = mbsp_pkg::KIND_SYSEX;
					res.first_value = {7'd0, in_byte};
					res.sysex_last  = packet_end;
					np              = mbsp_pkg::PH_SYSEX;
				end else if (in_byte[7]) begin
					if (in_byte[7:4] == mbsp_pkg::TYPE_SYSTEM) begin
						np = mbsp_pkg::PH_SKIP;
					end else begin
						nxt.last_status = in_byte;
						np              = mbsp_pkg::PH_DATA1;
					end
				end else if (cur.last_status == 8'd0) begin
					// Data with no running status: drop the rest of the packet.
					np = mbsp_pkg::PH_SKIP;
				end else if (mbsp_pkg::needs_two(cur.last_status)) begin
					nxt.held = in_byte;
					np       = mbsp_pkg::PH_DATA2;
				end else begin
					emit = 1'b1;
					res  = mbsp_pkg::channel_event(cur.last_status, in_byte, 8'd0);
				end
			end
		endcase
		// Every packet boundary returns the parser to idle.
		nxt.phase = packet_end ? mbsp_pkg::PH_IDLE : np;
	end

endmodule

`default_nettype wire

/* design/mbsp_out_reg.sv */
// ----------------------------------------------------------------------------
// MIDI byte stream parser result register
// Holds one event until the sink takes it; reports when it can load.
// ----------------------------------------------------------------------------
`default_nettype none

module mbsp_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  mbsp_pkg::result_t res,
	output logic              free,
	mbsp_event_if.source      events
);

	logic              valid_q;
	mbsp_pkg::result_t res_q;

	// The register can take a new event when empty or being drained.
	assign free = !valid_q || events.ready;

	// Valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (events.ready) begin
			valid_q <= 1'b0;
		end
	end

	// Payload.
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign events.valid        = valid_q;
	assign events.event_kind   = res_q.event_kind;
	assign events.channel      = res_q.channel;
	assign events.first_value  = res_q.first_value;
	assign events.second_value = res_q.second_value;
	assign events.sysex_last   = res_q.sysex_last;

endmodule

`default_nettype wire

/* design/midi_byte_stream_parser.sv */
// ----------------------------------------------------------------------------
// MIDI byte stream parser
// Running-status MIDI parser producing channel events and sysex bytes.
// ----------------------------------------------------------------------------
// The parser takes one byte per clock cycle and returns at most one event
// per byte. A byte is captured in an input register, decoded combinationally
// against the parser state, and the event lands in a result register, which
// presents it on the output until the sink takes it. The throughput of one
// byte per cycle is held as long as the event sink takes events; when the
// result register is full and not drained, a byte that would produce an
// event waits in the input register and input ready drops.
`default_nettype none

module midi_byte_stream_parser (
	input  logic          clk,
	input  logic          arst_n,
	mbsp_byte_if.sink     bytes,
	mbsp_event_if.source  events
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              end_s1;
	mbsp_pkg::state_t  state_q;
	mbsp_pkg::state_t  state_nxt;
	logic              emit;
	mbsp_pkg::result_t res;
	logic              out_free;
	logic              proc;
	logic              accept;

	// A held byte is processed when its event (if any) has room.
	assign proc         = valid_s1 && (!emit || out_free);
	assign bytes.ready  = !valid_s1 || proc;
	assign accept       = bytes.valid && bytes.ready;

	// Input register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= bytes.in_byte;
			end_s1  <= bytes.packet_end;
		end
	end

	// Parser state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.last_status <= 8'd0;
			state_q.phase       <= mbsp_pkg::PH_IDLE;
			state_q.held        <= 8'd0;
		end else if (proc) begin
			state_q <= state_nxt;
		end
	end

	mbsp_decode u_decode (
		.cur        (state_q),
		.in_byte    (byte_s1),
		.packet_end (end_s1),
		.nxt        (state_nxt),
		.emit       (emit),
		.res        (res)
	);

	mbsp_out_reg u_out_reg (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (proc && emit),
		.res    (res),
		.free   (out_free),
		.events (events)
	);

	// A processed byte that ends a packet leaves the parser idle.
	a_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && end_s1) |=> (state_q.phase == mbsp_pkg::PH_IDLE))
		else $error("parser not idle after packet end");

	// Every emitted event shows up on the output the next cycle.
	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && emit) |=> events.valid)
		else $error("emitted event lost");

	// Running status is either empty or a channel status byte.
	a_status_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.last_status == 8'd0) ||
		(state_q.last_status[7] && (state_q.last_status[7:4] != mbsp_pkg::TYPE_SYSTEM)))
		else $error("bad running status");

	// An empty input register always takes a byte.
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> bytes.ready)
		else $error("input stalled while empty");

endmodule

`default_nettype wire

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI byte stream parser testbench
// Drives packets of MIDI bytes into the parser and checks every event it
// returns against a running-status parser kept inside the bench. Directed
// packets cover each message type and the skip, sysex and truncation cases,
// then random packets run under several idle and stall mixes.
// ----------------------------------------------------------------------------

module testbench;

	localparam int CYCLE_LIMIT = 500000;

	// One byte on the wire together with its packet end flag.
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} wire_byte_t;

	logic clk;
	logic arst_n;

	mbsp_byte_if  byte_ch ();
	mbsp_event_if event_ch ();

	midi_byte_stream_parser dut (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (byte_ch),
		.events (event_ch)
	);

	wire_byte_t          byte_queue[$];
	mbsp_pkg::result_t   expected_events[$];
	logic [7:0]          packet_bytes[$];

	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned errors         = 0;
	int unsigned cycles         = 0;

	// Parser state mirrored by the bench.
	logic [7:0]        run_status = 8'd0;
	mbsp_pkg::phase_t  parse_ph   = mbsp_pkg::PH_IDLE;
	logic [7:0]        held_d1    = 8'd0;

	// Status byte that the packet generator last sent.
	logic [7:0] gen_status = 8'd0;

	// Clock and the single reset pulse.
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		fork
			forever #1 clk = ~clk;
			begin
				repeat (4) @(posedge clk);
				@(negedge clk);
				arst_n = 1'b1;
			end
		join
	end

	// Status types that take two data bytes.
	function automatic bit two_data(input logic [7:0] st);
		return st[7:4] == mbsp_pkg::TYPE_NOTE_OFF || st[7:4] == mbsp_pkg::TYPE_NOTE_ON ||
			st[7:4] == mbsp_pkg::TYPE_POLY_PRESS || st[7:4] == mbsp_pkg::TYPE_CONTROLLER ||
			st[7:4] == mbsp_pkg::TYPE_BEND;
	endfunction

	// Event for a completed channel message.
	function automatic mbsp_pkg::result_t channel_msg(input logic [7:0] st,
		input logic [7:0] d1, input logic [7:0] d2);
		mbsp_pkg::result_t r;
		r = '0;
		r.channel = st[3:0];
		r.first_value = 15'(d1);
		case (st[7:4])
			mbsp_pkg::TYPE_NOTE_OFF: begin
				r.event_kind = mbsp_pkg::KIND_NOTE_OFF;
				r.second_value = d2;
			end
			mbsp_pkg::TYPE_NOTE_ON: begin
				// Zero velocity turns the note on into a note off.
				if (d2 == 8'd0) begin
					r.event_kind = mbsp_pkg::KIND_NOTE_OFF;
				end else begin
					r.event_kind = mbsp_pkg::KIND_NOTE_ON;
					r.second_value = d2;
				end
			end
			mbsp_pkg::TYPE_POLY_PRESS: begin
				r.event_kind = mbsp_pkg::KIND_POLY_PRESS;
				r.second_value = d2;
			end
			mbsp_pkg::TYPE_CONTROLLER: begin
				r.event_kind = mbsp_pkg::KIND_CONTROLLER;
				r.second_value = d2;
			end
			mbsp_pkg::TYPE_PROGRAM: r.event_kind = mbsp_pkg::KIND_PROGRAM;
			mbsp_pkg::TYPE_CHAN_PRESS: r.event_kind = mbsp_pkg::KIND_CHAN_PRESS;
			default: begin
				r.event_kind = mbsp_pkg::KIND_BEND;
				r.first_value = 15'(d1) | {d2, 7'd0};
			end
		endcase
		return r;
	endfunction

	// Advance the mirrored parser by one byte; returns 1 when an event results.
	function automatic bit parse_byte(input logic [7:0] b, input logic last,
		output mbsp_pkg::result_t ev);
		mbsp_pkg::phase_t nxt;
		bit hit;
		nxt = mbsp_pkg::PH_IDLE;
		hit = 1'b0;
		ev = '0;
		case (parse_ph)
			mbsp_pkg::PH_DATA1: begin
				if (two_data(run_status)) begin
					held_d1 = b;
					nxt = mbsp_pkg::PH_DATA2;
				end else begin
					ev = channel_msg(run_status, b, 8'd0);
					hit = 1'b1;
				end
			end
			mbsp_pkg::PH_DATA2: begin
				ev = channel_msg(run_status, held_d1, b);
				hit = 1'b1;
			end
			mbsp_pkg::PH_SYSEX: begin
				ev.event_kind = mbsp_pkg::KIND_SYSEX;
				ev.first_value = 15'(b);
				ev.sysex_last = (b == mbsp_pkg::SYSEX_END) || last;
				hit = 1'b1;
				nxt = ev.sysex_last ? mbsp_pkg::PH_IDLE : mbsp_pkg::PH_SYSEX;
			end
			mbsp_pkg::PH_SKIP: nxt = mbsp_pkg::PH_SKIP;
			default: begin
				// Message boundary.
				if (b == mbsp_pkg::SYSEX_START) begin
					ev.event_kind = mbsp_pkg::KIND_SYSEX;
					ev.first_value = 15'(b);
					ev.sysex_last = last;
					hit = 1'b1;
					nxt = mbsp_pkg::PH_SYSEX;
				end else if (b[7]) begin
					if (b[7:4] == mbsp_pkg::TYPE_SYSTEM) begin
						nxt = mbsp_pkg::PH_SKIP;
					end else begin
						run_status = b;
						nxt = mbsp_pkg::PH_DATA1;
					end
				end else if (run_status == 8'd0) begin
					nxt = mbsp_pkg::PH_SKIP;
				end else if (two_data(run_status)) begin
					held_d1 = b;
					nxt = mbsp_pkg::PH_DATA2;
				end else begin
					ev = channel_msg(run_status, b, 8'd0);
					hit = 1'b1;
				end
			end
		endcase
		parse_ph = last ? mbsp_pkg::PH_IDLE : nxt;
		return hit;
	endfunction

	// Byte driver: presents queued bytes and predicts on each transaction.
	always @(posedge clk or negedge arst_n) begin
		bit sent;
		mbsp_pkg::result_t ev;
		wire_byte_t item;
		if (!arst_n) begin
			byte_ch.valid <= 1'b0;
			byte_ch.in_byte <= 8'd0;
			byte_ch.packet_end <= 1'b0;
		end else begin
			sent = byte_ch.valid && byte_ch.ready;
			if (sent) begin
				if (parse_byte(byte_ch.in_byte, byte_ch.packet_end, ev))
					expected_events.push_back(ev);
			end
			if (!byte_ch.valid || sent) begin
				if (byte_queue.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
					item = byte_queue.pop_front();
					byte_ch.valid <= 1'b1;
					byte_ch.in_byte <= item.data;
					byte_ch.packet_end <= item.last;
				end else begin
					byte_ch.valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string field, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
			errors++;
		end
	endtask

	// Event monitor: random backpressure and in-order comparison.
	always @(posedge clk or negedge arst_n) begin
		mbsp_pkg::result_t want;
		if (!arst_n) begin
			event_ch.ready <= 1'b0;
		end else begin
			if (event_ch.valid && event_ch.ready) begin
				if (expected_events.size() == 0) begin
					$error("unexpected event: kind %0d channel %0d first 0x%0h",
						event_ch.event_kind, event_ch.channel, event_ch.first_value);
					errors++;
				end else begin
					want = expected_events.pop_front();
					check_field("event_kind", want.event_kind, event_ch.event_kind);
					check_field("channel", want.channel, event_ch.channel);
					check_field("first_value", want.first_value, event_ch.first_value);
					check_field("second_value", want.second_value, event_ch.second_value);
					check_field("sysex_last", want.sysex_last, event_ch.sysex_last);
				end
			end
			event_ch.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic put(input logic [7:0] b, input logic last);
		byte_queue.push_back('{data: b, last: last});
	endtask

	// Data byte: mostly 7-bit, some zero, some with the top bit set.
	function automatic logic [7:0] data_byte();
		int unsigned r;
		r = $urandom_range(99, 0);
		if (r < 8)
			return 8'd0;
		if (r < 18)
			return 8'($urandom_range(255, 0));
		return 8'($urandom_range(127, 0));
	endfunction

	// Channel message, either complete or cut one data byte short.
	task automatic add_channel_msg(input bit complete);
		int need;
		if (gen_status == 8'd0 || !complete || $urandom_range(99, 0) < 55) begin
			gen_status = {1'b1, 3'($urandom_range(6, 0)), 4'($urandom_range(15, 0))};
			packet_bytes.push_back(gen_status);
		end
		need = two_data(gen_status) ? 2 : 1;
		if (!complete)
			need--;
		repeat (need) packet_bytes.push_back(data_byte());
	endtask

	// Sysex span, closed by F7 or left open to the packet end.
	task automatic add_sysex(input bit closed);
		packet_bytes.push_back(mbsp_pkg::SYSEX_START);
		repeat ($urandom_range(6, 0)) packet_bytes.push_back(8'($urandom_range(127, 0)));
		if (closed)
			packet_bytes.push_back(mbsp_pkg::SYSEX_END);
	endtask

	// One random packet; mostly well formed, some truncated, skipped or noise.
	task automatic add_packet();
		int unsigned pick;
		bit closed;
		packet_bytes.delete();
		pick = $urandom_range(99, 0);
		if (pick < 60) begin
			repeat ($urandom_range(4, 1)) add_channel_msg(1'b1);
			if ($urandom_range(9, 0) == 0)
				add_sysex(1'($urandom_range(1, 0)));
		end else if (pick < 75) begin
			closed = ($urandom_range(3, 0) != 0);
			add_sysex(closed);
			if (closed && $urandom_range(2, 0) == 0)
				add_channel_msg(1'b1);
		end else if (pick < 85) begin
			if ($urandom_range(1, 0))
				add_channel_msg(1'b1);
			add_channel_msg(1'b0);
		end else if (pick < 92) begin
			packet_bytes.push_back(8'hF1 + 8'($urandom_range(14, 0)));
			repeat ($urandom_range(3, 0)) packet_bytes.push_back(8'($urandom_range(255, 0)));
		end else begin
			// Noise with random packet boundaries.
			repeat ($urandom_range(5, 1))
				put(8'($urandom_range(255, 0)), 1'($urandom_range(1, 0)));
			return;
		end
		foreach (packet_bytes[i])
			put(packet_bytes[i], i == packet_bytes.size() - 1);
	endtask

	// Hold off until every queued byte is taken and every event has come back.
	task automatic wait_drained();
		@(negedge clk);
		while (byte_queue.size() != 0 || byte_ch.valid || expected_events.size() != 0)
			@(negedge clk);
	endtask

	// Stimulus sequence.
	initial begin
		int unsigned send_mix[5];
		int unsigned stall_mix[5];
		int unsigned quota[5];
		send_mix = '{0, 88, 0, 25, 0};
		stall_mix = '{0, 0, 88, 25, 0};
		quota = '{400, 350, 350, 400, 300};
		wait (arst_n === 1'b1);

		// Orphan data with no running status skips the packet.
		put(8'h00, 1'b0); put(8'h7F, 1'b1);
		// Note on, then running status with zero velocity.
		put(8'h90, 1'b0); put(8'h3C, 1'b0); put(8'h64, 1'b0); put(8'h3C, 1'b0);
		put(8'h00, 1'b1);
		put(8'h8F, 1'b0); put(8'h00, 1'b0); put(8'h7F, 1'b1);
		// Data bytes with the top bit set are taken as data.
		put(8'hA5, 1'b0); put(8'hFF, 1'b0); put(8'h80, 1'b1);
		// Controller cut short by the packet end.
		put(8'hB3, 1'b0); put(8'h07, 1'b1);
		put(8'hCA, 1'b0); put(8'h7F, 1'b1);
		put(8'hD1, 1'b0); put(8'h80, 1'b1);
		put(8'hEE, 1'b0); put(8'hFF, 1'b0); put(8'hFF, 1'b1);
		// Sysex closed by F7, then a truncated running-status bend.
		put(8'hF0, 1'b0); put(8'h01, 1'b0); put(8'hF7, 1'b0); put(8'h20, 1'b1);
		// Sysex closed by the packet end, system status skip, lone F0.
		put(8'hF0, 1'b0); put(8'h42, 1'b1);
		put(8'hF8, 1'b0); put(8'h12, 1'b1);
		put(8'hF0, 1'b1);
		wait_drained();

		// Random packets under each idle and stall mix.
		foreach (quota[p]) begin
			send_idle_pct = send_mix[p];
			recv_stall_pct = stall_mix[p];
			while (byte_queue.size() < quota[p])
				add_packet();
			wait_drained();
		end

		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
